// ===== rtl/dcds_pkg.sv =====
// Package: shared types, constants and helpers of the descriptor chain DMA sequencer.
package dcds_pkg;

  // Number of descriptor slots that the design provides.
  localparam int DESCRIPTOR_SLOTS = 16;

  // Width of a descriptor index as it travels in requests and results.
  localparam int SLOT_W = 4;

  // Only the first sixteen slots can be addressed through a four-bit index.
  localparam int TABLE_DEPTH = (DESCRIPTOR_SLOTS < (1 << SLOT_W)) ?
                               DESCRIPTOR_SLOTS : (1 << SLOT_W);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Width used to compare an index against the slot count.
  localparam int LIMIT_W = 9;

  // Descriptor mode codes.
  localparam logic [1:0] MODE_SUSPENDED = 2'd0;
  localparam logic [1:0] MODE_TRANSFER  = 2'd1;

  // Request kinds after classification.
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // One classified request as it waits in the queue.
  typedef struct packed {
    op_e         kind;
    logic        enable;
    logic [31:0] word;
    logic [3:0]  idx;
    logic        write_ok;
    logic [3:0]  next;
    logic [31:0] start;
    logic [1:0]  mode;
    logic [31:0] count;
    logic [31:0] stride;
  } cmd_t;

  // True when the index names a slot that exists.
  function automatic logic slot_ok(input logic [SLOT_W-1:0] i);
    slot_ok = ({{(LIMIT_W-SLOT_W){1'b0}}, i} < LIMIT_W'(DESCRIPTOR_SLOTS));
  endfunction

endpackage

// ===== rtl/dcds_front.sv =====
// Front end: unpacks and classifies incoming requests.
module dcds_front (
  input  logic              s_valid_i,
  input  logic [1:0]        s_user_i,
  input  logic [143:0]      s_data_i,
  output logic              cmd_valid_o,
  output dcds_pkg::cmd_t    cmd_o
);

  // Map the operation code onto a request kind and unpack the payload.
  always_comb begin
    cmd_o = '0;
    // Every operation code has a kind of its own; the unused code changes no state but still reports.
    cmd_o.kind     = dcds_pkg::op_e'(s_user_i);
    cmd_o.enable   = s_data_i[0];
    cmd_o.word     = s_data_i[32:1];
    cmd_o.idx      = s_data_i[36:33];
    cmd_o.next     = s_data_i[40:37];
    cmd_o.start    = s_data_i[72:41];
    cmd_o.mode     = s_data_i[74:73];
    cmd_o.count    = s_data_i[106:75];
    cmd_o.stride   = s_data_i[138:107];
    // A write to a slot beyond the table is dropped.
    cmd_o.write_ok = dcds_pkg::slot_ok(s_data_i[36:33]);
  end

  assign cmd_valid_o = s_valid_i;

endmodule

// ===== rtl/dcds_queue.sv =====
// Two-entry request queue between the front end and the execution stage.
module dcds_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  dcds_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output dcds_pkg::cmd_t pop_cmd_o
);

  dcds_pkg::cmd_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push, pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_cmd_o    = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== rtl/dcds_back.sv =====
// Execution stage: descriptor tables, sequencer state and the result register.
module dcds_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           direction_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  dcds_pkg::cmd_t cmd_i,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output logic [71:0]    m_data_o
);

  localparam int DEPTH = dcds_pkg::TABLE_DEPTH;
  localparam int IW    = dcds_pkg::IDX_W;

  // Descriptor tables, undefined until written.
  logic [3:0]  next_tbl_q   [DEPTH];
  logic [31:0] start_tbl_q  [DEPTH];
  logic [1:0]  mode_tbl_q   [DEPTH];
  logic [31:0] count_tbl_q  [DEPTH];
  logic [31:0] stride_tbl_q [DEPTH];

  logic [3:0]  cur_q, cur_d;
  logic [31:0] addr_q, addr_d;
  logic [31:0] rem_q, rem_d;
  logic        out_valid_q;
  logic [71:0] out_data_q, out_data_d;

  logic        exec;
  logic        cur_ok, sel_ok, load_ok, write_hit;
  logic [3:0]  sel_idx, load_idx, link;
  logic [1:0]  mode_cur, mode_sel;
  logic [31:0] stride_cur, load_start, load_count, rem_dec;
  logic [31:0] res_addr, res_word;
  logic        res_rd, res_wr, res_done, res_susp;
  logic [3:0]  res_active;

  // A request executes whenever the result register is free or being taken.
  assign cmd_ready_o = !out_valid_q || m_ready_i;
  assign exec        = cmd_valid_i && cmd_ready_o;
  assign m_valid_o   = out_valid_q;
  assign m_data_o    = out_data_q;

  // Table reads: link and stride of the current slot, mode of the current
  // slot or of slot zero on a restart, start and count of the slot being loaded.
  always_comb begin
    cur_ok     = dcds_pkg::slot_ok(cur_q);
    link       = cur_ok ? next_tbl_q[cur_q[IW-1:0]] : 4'd0;
    stride_cur = cur_ok ? stride_tbl_q[cur_q[IW-1:0]] : 32'd0;
    mode_cur   = cur_ok ? mode_tbl_q[cur_q[IW-1:0]] : dcds_pkg::MODE_SUSPENDED;
    sel_idx    = (cmd_i.kind == dcds_pkg::OP_RESTART) ? 4'd0 : cur_q;
    sel_ok     = dcds_pkg::slot_ok(sel_idx);
    mode_sel   = sel_ok ? mode_tbl_q[sel_idx[IW-1:0]] : dcds_pkg::MODE_SUSPENDED;
    load_idx   = (cmd_i.kind == dcds_pkg::OP_RESTART) ? 4'd0 : link;
    load_ok    = dcds_pkg::slot_ok(load_idx);
    load_start = load_ok ? start_tbl_q[load_idx[IW-1:0]] : 32'd0;
    load_count = load_ok ? count_tbl_q[load_idx[IW-1:0]] : 32'd0;
  end

  // Execute one request and form its result.
  always_comb begin
    cur_d      = cur_q;
    addr_d     = addr_q;
    rem_d      = rem_q;
    rem_dec    = rem_q - 32'd1;
    write_hit  = cmd_i.write_ok && (cmd_i.idx == cur_q);
    res_addr   = 32'd0;
    res_rd     = 1'b0;
    res_wr     = 1'b0;
    res_word   = 32'd0;
    res_done   = 1'b0;
    res_active = cur_q;
    res_susp   = (mode_cur == dcds_pkg::MODE_SUSPENDED);
    case (cmd_i.kind)
      dcds_pkg::OP_TICK: begin
        if (cmd_i.enable && (mode_cur != dcds_pkg::MODE_SUSPENDED)) begin
          if (mode_cur == dcds_pkg::MODE_TRANSFER) begin
            res_addr = addr_q;
            res_wr   = direction_i;
            res_rd   = !direction_i;
            res_word = direction_i ? cmd_i.word : 32'd0;
            addr_d   = addr_q + stride_cur;
          end
          rem_d = rem_dec;
          // Count exhausted: follow the link and load that descriptor.
          if (rem_dec == 32'd0) begin
            res_done = 1'b1;
            cur_d    = link;
            addr_d   = load_start;
            rem_d    = load_count;
          end
        end
      end
      dcds_pkg::OP_WRITE: begin
        // Writing the active slot changes its mode at once.
        if (write_hit) begin
          res_susp = (cmd_i.mode == dcds_pkg::MODE_SUSPENDED);
        end
      end
      dcds_pkg::OP_RESTART: begin
        cur_d      = 4'd0;
        addr_d     = load_start;
        rem_d      = load_count;
        res_active = 4'd0;
        res_susp   = (mode_sel == dcds_pkg::MODE_SUSPENDED);
      end
      default: begin
      end
    endcase
    out_data_d = {res_susp, res_done, res_active, res_word, res_wr, res_rd, res_addr};
  end

  // Sequencer state and result handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= 4'd0;
      addr_q      <= 32'd0;
      rem_q       <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (exec) begin
        cur_q  <= cur_d;
        addr_q <= addr_d;
        rem_q  <= rem_d;
      end
      if (exec) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload and descriptor tables.
  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_data_q <= out_data_d;
    end
    if (exec && (cmd_i.kind == dcds_pkg::OP_WRITE) && cmd_i.write_ok) begin
      next_tbl_q[cmd_i.idx[IW-1:0]]   <= cmd_i.next;
      start_tbl_q[cmd_i.idx[IW-1:0]]  <= cmd_i.start;
      mode_tbl_q[cmd_i.idx[IW-1:0]]   <= cmd_i.mode;
      count_tbl_q[cmd_i.idx[IW-1:0]]  <= cmd_i.count;
      stride_tbl_q[cmd_i.idx[IW-1:0]] <= cmd_i.stride;
    end
  end

endmodule

// ===== rtl/descriptor_chain_dma_sequencer_unit.sv =====
// Top level of the descriptor chain DMA sequencer: front end, request queue, execution stage.
// An accepted request passes through the request queue and then the result register.
// Throughput: one request per cycle while results are taken; the execution stage, with the
// descriptor tables held in registers, completes one tick, write or restart each cycle.
// Stalls: while a result waits, the two-entry queue takes up to two requests.
// Reset clears the pointer, address, count, direction, queue and result valid.
module descriptor_chain_dma_sequencer_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Request stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: enable, stream_in_word, entry_index, entry_next,
  // entry_start, entry_mode, entry_count, entry_stride, zero fill.
  input  logic [143:0] s_axis_tdata,
  // tuser: operation.
  input  logic [1:0]   s_axis_tuser,
  // Result stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata from bit 0: mem_address, mem_read, mem_write, write_word,
  // active_index, descriptor_done, suspended.
  output logic [71:0]  m_axis_tdata,
  // Configuration port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic           front_valid;
  dcds_pkg::cmd_t front_cmd;
  logic           q_valid, q_ready;
  dcds_pkg::cmd_t q_cmd;
  logic           dir_q;

  // Configuration register: transfer direction.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, dir_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      dir_q <= pwdata[0];
    end
  end

  dcds_front u_front (
    .s_valid_i   (s_axis_tvalid),
    .s_user_i    (s_axis_tuser),
    .s_data_i    (s_axis_tdata),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd)
  );

  dcds_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (s_axis_tready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_cmd_o    (q_cmd)
  );

  dcds_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .direction_i (dir_q),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata)
  );

endmodule

// ===== tb/descriptor_chain_dma_sequencer_unit_test.sv =====
// Testbench for the descriptor chain DMA sequencer: directed and random requests.
module descriptor_chain_dma_sequencer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // The two descriptor modes that the package does not name.
  localparam logic [1:0] MODE_WAIT     = 2'd2;
  localparam logic [1:0] MODE_WAIT_ALT = 2'd3;

  // Direction register and its settings.
  localparam logic [2:0] DIR_REG_ADDR = 3'd0;
  localparam logic       DIR_MM2S     = 1'b0;
  localparam logic       DIR_S2MM     = 1'b1;

  localparam int RESULT_LATENCY = 2;
  localparam int IDLE_LIMIT     = 3000;
  localparam int HOLD_AFTER     = 150;
  localparam int LONG_HOLD      = 400;
  localparam int RANDOM_PHASES  = 4;
  localparam int PHASE_REQUESTS = 280;
  localparam int DIRECTED_ROWS  = 25;

  // Request fields as they sit in tdata, last member in the lowest bits.
  typedef struct packed {
    logic [31:0] stride;
    logic [31:0] count;
    logic [1:0]  mode;
    logic [31:0] start;
    logic [3:0]  nxt;
    logic [3:0]  idx;
    logic [31:0] word;
    logic        enable;
  } dma_fields_t;

  // Result fields as they sit in tdata, last member in the lowest bits.
  typedef struct packed {
    logic        suspended;
    logic        done;
    logic [3:0]  active;
    logic [31:0] wword;
    logic        mem_wr;
    logic        mem_rd;
    logic [31:0] addr;
  } dma_res_t;

  typedef struct {
    dcds_pkg::op_e op;
    dma_fields_t   f;
    bit            typed;
    dma_res_t      res;
  } directed_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // tdata from bit 0: enable, stream_in_word, entry_index, entry_next,
  // entry_start, entry_mode, entry_count, entry_stride, zero fill.
  logic [143:0] s_axis_tdata = '0;
  // tuser: operation.
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // tdata from bit 0: mem_address, mem_read, mem_write, write_word,
  // active_index, descriptor_done, suspended.
  logic [71:0]  m_axis_tdata;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  descriptor_chain_dma_sequencer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Predictor copy of the descriptor tables and the sequencer registers.
  logic [3:0]  next_link  [dcds_pkg::DESCRIPTOR_SLOTS];
  logic [31:0] start_addr [dcds_pkg::DESCRIPTOR_SLOTS];
  logic [1:0]  slot_mode  [dcds_pkg::DESCRIPTOR_SLOTS];
  logic [31:0] slot_count [dcds_pkg::DESCRIPTOR_SLOTS];
  logic [31:0] slot_stride[dcds_pkg::DESCRIPTOR_SLOTS];
  logic [3:0]  cur_slot = '0;
  logic [31:0] cur_addr = '0;
  logic [31:0] left_count = '0;
  logic        dir_cfg = DIR_MM2S;

  dma_res_t pending_accesses[$];
  int       access_errors = 0;
  int       results_seen = 0;
  int       burst_left = 0;
  int       idle_cycles = 0;

  // Directed requests. Rows with a typed result are checked against that value.
  directed_row_t directed_tbl [DIRECTED_ROWS] = '{
    // Fill four slots: a transfer, a wait, a suspended and a mode-three descriptor.
    '{dcds_pkg::OP_WRITE, '{idx: 4'd0, nxt: 4'd1, start: 32'hFFFF_FFFF,
                 mode: dcds_pkg::MODE_TRANSFER,
                 count: 32'd2, stride: 32'd1, enable: 1'b1, default: '0},
      1'b1, '{default: '0}},
    '{dcds_pkg::OP_WRITE, '{idx: 4'd1, nxt: 4'd2, start: 32'h1000_0000, mode: MODE_WAIT,
                 count: 32'd1, default: '0},
      1'b1, '{default: '0}},
    '{dcds_pkg::OP_WRITE, '{idx: 4'd2, nxt: 4'd3, mode: dcds_pkg::MODE_SUSPENDED,
                 count: 32'd5, default: '0},
      1'b1, '{default: '0}},
    '{dcds_pkg::OP_WRITE, '{idx: 4'd3, nxt: 4'd0, start: 32'hAAAA_5555, mode: MODE_WAIT_ALT,
                 count: 32'd1, stride: 32'hFFFF_FFFF, default: '0},
      1'b1, '{default: '0}},
    // A tick straight after reset: address zero and a count that wraps.
    '{dcds_pkg::OP_TICK, '{enable: 1'b1, word: 32'h5A5A_A5A5, default: '0},
      1'b1, '{mem_rd: 1'b1, default: '0}},
    '{dcds_pkg::OP_RESTART, '{default: '0}, 1'b1, '{default: '0}},
    // A disabled tick changes nothing.
    '{dcds_pkg::OP_TICK, '{enable: 1'b0, word: 32'hFFFF_FFFF, default: '0},
      1'b1, '{default: '0}},
    // The address wraps through zero, then the count runs out and the link is taken.
    '{dcds_pkg::OP_TICK, '{enable: 1'b1, default: '0},
      1'b1, '{addr: 32'hFFFF_FFFF, mem_rd: 1'b1, default: '0}},
    '{dcds_pkg::OP_TICK, '{enable: 1'b1, default: '0},
      1'b1, '{mem_rd: 1'b1, done: 1'b1, default: '0}},
    '{dcds_pkg::OP_TICK, '{enable: 1'b1, default: '0},
      1'b1, '{active: 4'd1, done: 1'b1, default: '0}},
    // A suspended descriptor holds, and an unused operation only reports.
    '{dcds_pkg::OP_TICK, '{enable: 1'b1, default: '0},
      1'b1, '{active: 4'd2, suspended: 1'b1, default: '0}},
    '{dcds_pkg::OP_NONE, '{enable: 1'b1, word: 32'h0000_0001, default: '0},
      1'b1, '{active: 4'd2, suspended: 1'b1, default: '0}},
    // Rewriting the active descriptor: mode and stride now, start and count later.
    '{dcds_pkg::OP_WRITE, '{idx: 4'd2, nxt: 4'd3, start: 32'h1234_5678,
                 mode: dcds_pkg::MODE_TRANSFER,
                 count: 32'd3, stride: 32'h10, default: '0},
      1'b1, '{active: 4'd2, default: '0}},
    '{dcds_pkg::OP_TICK, '{enable: 1'b1, default: '0}, 1'b0, '{default: '0}},
    '{dcds_pkg::OP_TICK, '{enable: 1'b1, default: '0}, 1'b0, '{default: '0}},
    // Chain from a wait descriptor into mode three, which counts like a wait.
    '{dcds_pkg::OP_WRITE, '{idx: 4'd0, nxt: 4'd3, mode: MODE_WAIT, count: 32'd1,
                 default: '0},
      1'b0, '{default: '0}},
    '{dcds_pkg::OP_RESTART, '{default: '0}, 1'b0, '{default: '0}},
    '{dcds_pkg::OP_TICK, '{enable: 1'b1, default: '0}, 1'b1, '{done: 1'b1, default: '0}},
    '{dcds_pkg::OP_TICK, '{enable: 1'b1, default: '0},
      1'b1, '{active: 4'd3, done: 1'b1, default: '0}},
    // Field extremes: the top slot with every field at its maximum.
    '{dcds_pkg::OP_WRITE, '{idx: 4'd15, nxt: 4'd15, start: 32'hFFFF_FFFF, mode: MODE_WAIT_ALT,
                 count: 32'hFFFF_FFFF, stride: 32'hFFFF_FFFF, enable: 1'b1,
                 word: 32'hFFFF_FFFF},
      1'b1, '{default: '0}},
    '{dcds_pkg::OP_WRITE, '{idx: 4'd0, nxt: 4'd15, start: 32'hFFFF_FFFF,
                 mode: dcds_pkg::MODE_TRANSFER,
                 count: 32'd1, stride: 32'hFFFF_FFFF, default: '0},
      1'b1, '{default: '0}},
    '{dcds_pkg::OP_RESTART, '{default: '0}, 1'b1, '{default: '0}},
    '{dcds_pkg::OP_TICK, '{enable: 1'b1, default: '0},
      1'b1, '{addr: 32'hFFFF_FFFF, mem_rd: 1'b1, done: 1'b1, default: '0}},
    '{dcds_pkg::OP_TICK, '{enable: 1'b1, default: '0}, 1'b0, '{default: '0}},
    // Field minimums.
    '{dcds_pkg::OP_WRITE, '{mode: dcds_pkg::MODE_SUSPENDED, default: '0},
      1'b1, '{active: 4'd15, default: '0}}
  };

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Make a descriptor the current one.
  function automatic void load_slot(input logic [3:0] s);
    cur_slot   = s;
    cur_addr   = start_addr[s];
    left_count = slot_count[s];
  endfunction

  // Advance the predictor by one request and return the bus access it causes.
  function automatic dma_res_t sequence_step(input dcds_pkg::op_e op, input dma_fields_t f);
    dma_res_t   res;
    logic [1:0] md;
    logic [3:0] act;
    res = '0;
    if (op == dcds_pkg::OP_TICK) begin
      act = cur_slot;
      md  = slot_mode[act];
      if (f.enable && md != dcds_pkg::MODE_SUSPENDED) begin
        if (md == dcds_pkg::MODE_TRANSFER) begin
          res.addr = cur_addr;
          if (dir_cfg == DIR_S2MM) begin
            res.mem_wr = 1'b1;
            res.wword  = f.word;
          end else begin
            res.mem_rd = 1'b1;
          end
          cur_addr = cur_addr + slot_stride[act];
        end
        left_count = left_count - 32'd1;
        if (left_count == '0) begin
          res.done = 1'b1;
          load_slot(next_link[act]);
        end
      end
    end else begin
      if (op == dcds_pkg::OP_WRITE) begin
        next_link[f.idx]   = f.nxt;
        start_addr[f.idx]  = f.start;
        slot_mode[f.idx]   = f.mode;
        slot_count[f.idx]  = f.count;
        slot_stride[f.idx] = f.stride;
      end else if (op == dcds_pkg::OP_RESTART) begin
        load_slot(4'd0);
      end
      act = cur_slot;
    end
    res.active    = act;
    res.suspended = (slot_mode[act] == dcds_pkg::MODE_SUSPENDED);
    return res;
  endfunction

  // Draw a random request; counts are mostly short so that chains keep moving.
  function automatic void draw_request(output dcds_pkg::op_e op, output dma_fields_t f);
    int sel;
    sel = $urandom_range(0, 99);
    op = (sel < 72) ? dcds_pkg::OP_TICK :
         (sel < 88) ? dcds_pkg::OP_WRITE :
         (sel < 95) ? dcds_pkg::OP_RESTART : dcds_pkg::OP_NONE;
    f.enable = ($urandom_range(0, 9) != 0);
    f.word   = $urandom;
    f.idx    = 4'($urandom_range(0, 15));
    f.nxt    = 4'($urandom_range(0, 15));
    f.start  = $urandom;
    sel = $urandom_range(0, 99);
    f.mode = (sel < 8) ? dcds_pkg::MODE_SUSPENDED : (sel < 58) ? dcds_pkg::MODE_TRANSFER :
             (sel < 88) ? MODE_WAIT : MODE_WAIT_ALT;
    sel = $urandom_range(0, 99);
    f.count = (sel < 3) ? 32'd0 : (sel < 9) ? $urandom :
              (sel < 25) ? $urandom_range(7, 40) : $urandom_range(1, 6);
    f.stride = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom;
  endfunction

  // Offer one request, wait until it is taken, then record what it should cause.
  task automatic issue_request(input dcds_pkg::op_e op, input dma_fields_t f,
                               input bit typed, input dma_res_t typed_res);
    dma_res_t predicted;
    int       gap;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b0, f};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = sequence_step(op, f);
    pending_accesses.push_back(typed ? typed_res : predicted);
    // Bursts of random length, separated by random gaps.
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_accesses.size() != 0) @(posedge clk_i);
    repeat (RESULT_LATENCY + 2) @(posedge clk_i);
  endtask

  // Write the direction register through the configuration port.
  task automatic set_direction(input logic dir);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DIR_REG_ADDR;
    pwdata  <= {31'b0, dir};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    dir_cfg = dir;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Main stimulus: reset, directed table, then random phases in both directions.
  initial begin : stimulus
    dcds_pkg::op_e op;
    dma_fields_t   f;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    set_direction(DIR_MM2S);
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      issue_request(directed_tbl[i].op, directed_tbl[i].f, directed_tbl[i].typed,
                    directed_tbl[i].res);
    end
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph > 0) begin
        drain_results();
        set_direction((ph % 2 == 1) ? DIR_S2MM : DIR_MM2S);
      end else begin
        // Give every slot random contents before any link can reach it.
        for (int s = 0; s < dcds_pkg::DESCRIPTOR_SLOTS; s++) begin
          draw_request(op, f);
          f.idx = 4'(s);
          issue_request(dcds_pkg::OP_WRITE, f, 1'b0, '0);
        end
      end
      repeat (PHASE_REQUESTS) begin
        draw_request(op, f);
        issue_request(op, f, 1'b0, '0);
      end
    end
    drain_results();
    if (access_errors == 0 && pending_accesses.size() == 0) begin
      $display("descriptor_chain_dma_sequencer_unit: match");
    end else begin
      $display("descriptor_chain_dma_sequencer_unit: mismatch");
    end
    $finish;
  end

  // Result side: changing stall styles, and one long hold-off to back the block up.
  initial begin : result_sink
    int style;
    bit held;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end
      style = $urandom_range(0, 2);
      repeat ($urandom_range(16, 96)) begin
        @(negedge clk_i);
        case (style)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Compare each result with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    dma_res_t got;
    dma_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = dma_res_t'(m_axis_tdata);
      results_seen++;
      if (pending_accesses.size() == 0) begin
        access_errors++;
        if (access_errors <= 10) $display("%0t: result arrived with none expected", $time);
      end else begin
        want = pending_accesses.pop_front();
        if (got.addr !== want.addr || got.mem_rd !== want.mem_rd ||
            got.mem_wr !== want.mem_wr || got.wword !== want.wword ||
            got.active !== want.active || got.done !== want.done ||
            got.suspended !== want.suspended) begin
          access_errors++;
          if (access_errors <= 10) begin
            $display("%0t: expected addr=%h rd=%b wr=%b word=%h idx=%0d done=%b susp=%b",
                     $time, want.addr, want.mem_rd, want.mem_wr, want.wword,
                     want.active, want.done, want.suspended);
            $display("%0t: actual   addr=%h rd=%b wr=%b word=%h idx=%0d done=%b susp=%b",
                     $time, got.addr, got.mem_rd, got.mem_wr, got.wword,
                     got.active, got.done, got.suspended);
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves on either stream for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("descriptor_chain_dma_sequencer_unit: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

// ===== filelist.f =====
rtl/dcds_pkg.sv
rtl/dcds_front.sv
rtl/dcds_queue.sv
rtl/dcds_back.sv
rtl/descriptor_chain_dma_sequencer_unit.sv
tb/descriptor_chain_dma_sequencer_unit_test.sv
